// ----- design/gte_pkg.sv -----
// ----------------------------------------------------------------------------
// gte_pkg
// Shared types, codes and sizes for the graph traversal engine.
// ----------------------------------------------------------------------------
package gte_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;

  localparam int OPCODE_W   = 2;
  localparam int VERTEX_W   = 6;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [OPCODE_W-1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TRAVERSE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_VISITED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVERSAL_ORDER = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_STATUS,
    S_ADD_LINK,
    S_BFS_POP,
    S_BFS_HEAD,
    S_BFS_LOAD,
    S_DFS_TOP,
    S_DFS_CUR,
    S_DFS_LOAD,
    S_DFS_PUSH,
    S_EDGE,
    S_CHECK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                in_ready;
    logic                add_write;
    logic                rd_tail;
    logic                add_link;
    logic                clear_graph;
    logic                start_trav;
    logic                rd_head_v;
    logic                rd_head_t;
    logic                rd_head_w;
    logic                rd_pend_front;
    logic                rd_pend_top;
    logic                rd_cur;
    logic                rd_edge;
    logic                load_e_head;
    logic                load_e_cur;
    logic                next_e;
    logic                visit;
    logic                cur_save;
    logic                push_cur;
    logic                pop;
    logic                emit_status;
    logic                finish;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic                in_valid;
    logic [OPCODE_W-1:0] op;
    logic                add_range_bad;
    logic                trav_range_bad;
    logic                full;
    logic                head_valid_v;
    logic                queue_empty;
    logic                stack_empty;
    logic                edge_nil;
    logic                can_visit;
    logic                out_free;
    logic                order;
  } sts_t;

endpackage

// ----- design/gte_item_if.sv -----
// ----------------------------------------------------------------------------
// gte_item_if
// Input item channel: opcode and vertex operands.
// ----------------------------------------------------------------------------
interface gte_item_if;
  logic                          valid;
  logic                          ready;
  logic [gte_pkg::OPCODE_W-1:0]  opcode;
  logic [gte_pkg::VERTEX_W-1:0]  vertex;
  logic [gte_pkg::VERTEX_W-1:0]  neighbor_vertex;

  modport source (output valid, opcode, vertex, neighbor_vertex, input ready);
  modport sink   (input valid, opcode, vertex, neighbor_vertex, output ready);
endinterface

// ----- design/gte_result_if.sv -----
// ----------------------------------------------------------------------------
// gte_result_if
// Result channel: visited vertex or status, with last flag.
// ----------------------------------------------------------------------------
interface gte_result_if;
  logic                          valid;
  logic                          ready;
  logic [gte_pkg::VERTEX_W-1:0]  visited_vertex;
  logic [gte_pkg::STATUS_W-1:0]  status;
  logic                          last;

  modport source (output valid, visited_vertex, status, last, input ready);
  modport sink   (input valid, visited_vertex, status, last, output ready);
endinterface

// ----- design/gte_cfg_if.sv -----
// ----------------------------------------------------------------------------
// gte_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface gte_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gte_pkg::CFG_IDX_W-1:0]   index;
  logic [gte_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/gte_ctrl.sv -----
// ----------------------------------------------------------------------------
// gte_ctrl
// Sequencer for edge loads, clears and the two traversal walks.
// ----------------------------------------------------------------------------
module gte_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  gte_pkg::sts_t  sts,
  output gte_pkg::cmd_t  cmd
);

  gte_pkg::state_t                 state, state_next;
  logic [gte_pkg::STATUS_W-1:0]    st_code, st_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gte_pkg::S_IDLE;
      st_code <= gte_pkg::ST_VISITED;
    end else begin
      state   <= state_next;
      st_code <= st_code_next;
    end
  end

  always_comb begin
    state_next   = state;
    st_code_next = st_code;
    unique case (state)
      gte_pkg::S_IDLE: begin
        if (sts.in_valid) state_next = gte_pkg::S_DECODE;
      end
      gte_pkg::S_DECODE: begin
        unique case (sts.op)
          gte_pkg::OP_ADD_EDGE: begin
            if (sts.add_range_bad) begin
              st_code_next = gte_pkg::ST_OUT_RANGE;
              state_next   = gte_pkg::S_STATUS;
            end else if (sts.full) begin
              st_code_next = gte_pkg::ST_FULL;
              state_next   = gte_pkg::S_STATUS;
            end else if (sts.head_valid_v) begin
              state_next = gte_pkg::S_ADD_LINK;
            end else begin
              state_next = gte_pkg::S_IDLE;
            end
          end
          gte_pkg::OP_TRAVERSE: begin
            if (sts.trav_range_bad) begin
              st_code_next = gte_pkg::ST_OUT_RANGE;
              state_next   = gte_pkg::S_STATUS;
            end else if (sts.order) begin
              state_next = gte_pkg::S_DFS_PUSH;
            end else begin
              state_next = gte_pkg::S_BFS_POP;
            end
          end
          default: state_next = gte_pkg::S_IDLE;
        endcase
      end
      gte_pkg::S_STATUS: begin
        if (sts.out_free) state_next = gte_pkg::S_IDLE;
      end
      gte_pkg::S_ADD_LINK: state_next = gte_pkg::S_IDLE;
      gte_pkg::S_BFS_POP: begin
        state_next = sts.queue_empty ? gte_pkg::S_FINISH : gte_pkg::S_BFS_HEAD;
      end
      gte_pkg::S_BFS_HEAD: state_next = gte_pkg::S_BFS_LOAD;
      gte_pkg::S_BFS_LOAD: state_next = gte_pkg::S_EDGE;
      gte_pkg::S_DFS_TOP: begin
        state_next = sts.stack_empty ? gte_pkg::S_FINISH : gte_pkg::S_DFS_CUR;
      end
      gte_pkg::S_DFS_CUR:  state_next = gte_pkg::S_DFS_LOAD;
      gte_pkg::S_DFS_LOAD: state_next = gte_pkg::S_EDGE;
      gte_pkg::S_DFS_PUSH: state_next = gte_pkg::S_EDGE;
      gte_pkg::S_EDGE: begin
        if (!sts.edge_nil) begin
          state_next = gte_pkg::S_CHECK;
        end else if (sts.order) begin
          state_next = gte_pkg::S_DFS_TOP;
        end else begin
          state_next = gte_pkg::S_BFS_POP;
        end
      end
      gte_pkg::S_CHECK: begin
        if (!sts.can_visit) begin
          state_next = gte_pkg::S_EDGE;
        end else if (sts.out_free) begin
          state_next = sts.order ? gte_pkg::S_DFS_PUSH : gte_pkg::S_EDGE;
        end
      end
      gte_pkg::S_FINISH: begin
        if (sts.out_free) state_next = gte_pkg::S_IDLE;
      end
      default: state_next = gte_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.status = st_code;
    unique case (state)
      gte_pkg::S_IDLE: cmd.in_ready = 1'b1;
      gte_pkg::S_DECODE: begin
        unique case (sts.op)
          gte_pkg::OP_ADD_EDGE: begin
            if (!sts.add_range_bad && !sts.full) begin
              cmd.add_write = 1'b1;
              cmd.rd_tail   = sts.head_valid_v;
            end
          end
          gte_pkg::OP_TRAVERSE: begin
            if (!sts.trav_range_bad) begin
              cmd.start_trav = 1'b1;
              cmd.rd_head_v  = 1'b1;
            end
          end
          gte_pkg::OP_CLEAR: cmd.clear_graph = 1'b1;
          default: ;
        endcase
      end
      gte_pkg::S_STATUS:   cmd.emit_status = sts.out_free;
      gte_pkg::S_ADD_LINK: cmd.add_link = 1'b1;
      gte_pkg::S_BFS_POP:  cmd.rd_pend_front = !sts.queue_empty;
      gte_pkg::S_BFS_HEAD: cmd.rd_head_t = 1'b1;
      gte_pkg::S_BFS_LOAD: cmd.load_e_head = 1'b1;
      gte_pkg::S_DFS_TOP:  cmd.rd_pend_top = !sts.stack_empty;
      gte_pkg::S_DFS_CUR:  cmd.rd_cur = 1'b1;
      gte_pkg::S_DFS_LOAD: cmd.load_e_cur = 1'b1;
      gte_pkg::S_DFS_PUSH: cmd.push_cur = 1'b1;
      gte_pkg::S_EDGE: begin
        cmd.rd_edge = !sts.edge_nil;
        cmd.pop     = sts.edge_nil && sts.order;
      end
      gte_pkg::S_CHECK: begin
        if (!sts.can_visit) begin
          cmd.next_e = 1'b1;
        end else if (sts.out_free) begin
          cmd.visit     = 1'b1;
          cmd.next_e    = !sts.order;
          cmd.cur_save  = sts.order;
          cmd.rd_head_w = sts.order;
        end
      end
      gte_pkg::S_FINISH: cmd.finish = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ----- design/gte_dp.sv -----
// ----------------------------------------------------------------------------
// gte_dp
// Datapath: config registers, adjacency memories, pending list, visited
// marks and the result register.
// ----------------------------------------------------------------------------
module gte_dp #(
  parameter int MAX_VERTICES = gte_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = gte_pkg::MAX_EDGES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  gte_item_if.sink       items,
  gte_result_if.source   results,
  gte_cfg_if.sink        cfg,
  input  gte_pkg::cmd_t  cmd,
  output gte_pkg::sts_t  sts
);

  localparam int VIW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int PW  = $clog2(MAX_VERTICES + 1);
  localparam int EIW = $clog2(MAX_EDGES);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int VW  = gte_pkg::VERTEX_W;
  localparam int CW  = gte_pkg::CFG_DATA_W;

  localparam logic [EW-1:0] NO_EDGE = EW'(MAX_EDGES);
  localparam logic [CW-1:0] VC_MAX  = CW'(MAX_VERTICES);
  localparam logic [PW-1:0] PEND_MAX = PW'(MAX_VERTICES);

  // configuration
  logic [CW-1:0] vcount;
  logic          order;
  logic [CW-1:0] cfg_vc;

  assign cfg.ready = 1'b1;

  always_comb begin
    cfg_vc = cfg.data;
    if (cfg.data == '0) begin
      cfg_vc = CW'(1);
    end else if (cfg.data > VC_MAX) begin
      cfg_vc = VC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= VC_MAX;
      order  <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        gte_pkg::REG_VERTEX_COUNT:    vcount <= cfg_vc;
        gte_pkg::REG_TRAVERSAL_ORDER: order  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // latched input item
  logic [gte_pkg::OPCODE_W-1:0] op_q;
  logic [VW-1:0]                v_q, w_q;

  assign items.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      op_q <= items.opcode;
      v_q  <= items.vertex;
      w_q  <= items.neighbor_vertex;
    end
  end

  // walk registers
  logic [EW-1:0]         ec;
  logic [EW-1:0]         e;
  logic [VW-1:0]         t, nw, prev;
  logic [PW-1:0]         front, back;
  logic [MAX_VERTICES-1:0] vis, hv;

  // memory read registers
  logic [EW-1:0] head_rd, tail_rd, lnk_rd, cur_rd;
  logic [VW-1:0] tgt_rd, pend_rd;
  logic          hv_rd;
  logic [EW-1:0] headval;

  assign headval = hv_rd ? head_rd : NO_EDGE;

  logic [VIW-1:0] v_idx;
  assign v_idx = v_q[VIW-1:0];

  // head list memory, with valid bits cleared at once
  logic [EW-1:0]  head_mem [MAX_VERTICES];
  logic [VIW-1:0] head_ra;
  logic           head_re, head_we;

  assign head_we = cmd.add_write && !hv[v_idx];
  assign head_re = cmd.rd_head_v || cmd.rd_head_t || cmd.rd_head_w;

  always_comb begin
    head_ra = v_idx;
    if (cmd.rd_head_t) begin
      head_ra = pend_rd[VIW-1:0];
    end else if (cmd.rd_head_w) begin
      head_ra = tgt_rd[VIW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[v_idx] <= ec;
    if (head_re) begin
      head_rd <= head_mem[head_ra];
      hv_rd   <= hv[head_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_graph) begin
      hv <= '0;
    end else if (head_we) begin
      hv[v_idx] <= 1'b1;
    end
  end

  // tail memory
  logic [EW-1:0] tail_mem [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (head_we || cmd.add_link) tail_mem[v_idx] <= ec;
    if (cmd.rd_tail) tail_rd <= tail_mem[v_idx];
  end

  // edge table
  logic [VW-1:0]  tgt_mem [MAX_EDGES];
  logic [EW-1:0]  lnk_mem [MAX_EDGES];
  logic           lnk_we;
  logic [EIW-1:0] lnk_wa;
  logic [EW-1:0]  lnk_wd;

  assign lnk_we = cmd.add_write || cmd.add_link;
  assign lnk_wa = cmd.add_link ? tail_rd[EIW-1:0] : ec[EIW-1:0];
  assign lnk_wd = cmd.add_link ? ec : NO_EDGE;

  always_ff @(posedge clk) begin
    if (cmd.add_write) tgt_mem[ec[EIW-1:0]] <= w_q;
    if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
    if (cmd.rd_edge) begin
      tgt_rd <= tgt_mem[e[EIW-1:0]];
      lnk_rd <= lnk_mem[e[EIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_graph) begin
      ec <= '0;
    end else if (head_we || cmd.add_link) begin
      ec <= ec + EW'(1);
    end
  end

  // pending queue / stack
  logic [VW-1:0]  pend_mem [MAX_VERTICES];
  logic           pend_we, pend_re;
  logic [VIW-1:0] pend_wa, pend_ra;
  logic [VW-1:0]  pend_wd;

  assign pend_we = cmd.start_trav || cmd.visit;
  assign pend_wa = cmd.start_trav ? '0 : back[VIW-1:0];
  assign pend_wd = cmd.start_trav ? v_q : tgt_rd;
  assign pend_re = cmd.rd_pend_front || cmd.rd_pend_top;
  assign pend_ra = cmd.rd_pend_front ? front[VIW-1:0] : (back[VIW-1:0] - VIW'(1));

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    if (pend_re) pend_rd <= pend_mem[pend_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
    end else if (cmd.start_trav) begin
      front <= '0;
      back  <= PW'(1);
    end else begin
      if (cmd.rd_pend_front) front <= front + PW'(1);
      if (cmd.visit) begin
        back <= back + PW'(1);
      end else if (cmd.pop) begin
        back <= back - PW'(1);
      end
    end
  end

  // per-vertex neighbor cursor for depth-first walk
  logic [EW-1:0]  cur_mem [MAX_VERTICES];
  logic           cur_we;
  logic [VIW-1:0] cur_wa;
  logic [EW-1:0]  cur_wd;

  assign cur_we = cmd.cur_save || cmd.push_cur;
  assign cur_wa = cmd.cur_save ? t[VIW-1:0] : nw[VIW-1:0];
  assign cur_wd = cmd.cur_save ? lnk_rd : headval;

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    if (cmd.rd_cur) cur_rd <= cur_mem[pend_rd[VIW-1:0]];
  end

  // walk state
  always_ff @(posedge clk) begin
    if (cmd.rd_head_t || cmd.rd_cur) t <= pend_rd;
    else if (cmd.push_cur) t <= nw;

    if (cmd.start_trav) nw <= v_q;
    else if (cmd.rd_head_w) nw <= tgt_rd;

    if (cmd.start_trav) prev <= v_q;
    else if (cmd.visit) prev <= tgt_rd;

    if (cmd.load_e_head || cmd.push_cur) e <= headval;
    else if (cmd.load_e_cur) e <= cur_rd;
    else if (cmd.next_e) e <= lnk_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vis <= '0;
    end else if (cmd.start_trav) begin
      // only the start vertex is marked
      vis <= MAX_VERTICES'(1) << v_idx;
    end else if (cmd.visit) begin
      vis[tgt_rd[VIW-1:0]] <= 1'b1;
    end
  end

  // result register
  logic out_load;
  assign out_load = cmd.emit_status || cmd.visit || cmd.finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.visited_vertex <= cmd.emit_status ? '0 : prev;
      results.status         <= cmd.emit_status ? cmd.status : gte_pkg::ST_VISITED;
      results.last           <= cmd.emit_status || cmd.finish;
    end
  end

  // status to controller
  always_comb begin
    sts                = '0;
    sts.in_valid       = items.valid;
    sts.op             = op_q;
    sts.add_range_bad  = ({1'b0, v_q} >= vcount) || ({1'b0, w_q} >= vcount);
    sts.trav_range_bad = ({1'b0, v_q} >= vcount);
    sts.full           = (ec == NO_EDGE);
    sts.head_valid_v   = hv[v_idx];
    sts.queue_empty    = (front == back);
    sts.stack_empty    = (back == '0);
    sts.edge_nil       = (e == NO_EDGE);
    sts.can_visit      = ({1'b0, tgt_rd} < vcount) && !vis[tgt_rd[VIW-1:0]] &&
                         (back != PEND_MAX);
    sts.out_free       = !results.valid || results.ready;
    sts.order          = order;
  end

endmodule

// ----- design/graph_traversal_engine_top.sv -----
// ----------------------------------------------------------------------------
// graph_traversal_engine_top
// Directed graph store with breadth-first and depth-first traversal.
// ----------------------------------------------------------------------------
// One item is handled at a time. An edge add, a clear or an ignored opcode
// holds the engine through accept and decode; an edge add into a non-empty
// list adds a link state to write the link after a tail lookup. A status
// result holds it until the result register is free. A breadth-first walk
// reads each dequeued vertex and its head edge, then examines its edges in
// turn; a depth-first walk pushes each new vertex, reloads the stacked
// vertex and its saved edge cursor on each return, and examines its edges
// the same way. The adjacency memories have registered reads; a stalled
// result channel holds the walk. Results are held one behind so the final
// vertex carries last. No clearing pass is needed after reset.
module graph_traversal_engine_top #(
  parameter int MAX_VERTICES = gte_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = gte_pkg::MAX_EDGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  gte_item_if.sink      items,
  gte_result_if.source  results,
  gte_cfg_if.sink       cfg
);

  gte_pkg::cmd_t cmd;
  gte_pkg::sts_t sts;

  gte_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  gte_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

// ----- verif/gte_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gte_scoreboard
// Watches the item, result and config channels of the graph traversal
// engine, keeps a shadow graph, predicts each visit or status result and
// compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module gte_scoreboard (
  input  logic         clk,
  input  logic         rst,
  gte_item_if          items,
  gte_result_if        results,
  gte_cfg_if           cfg,
  output int           error_count,
  output int           awaited,
  output int           result_count
);

  localparam int NV = gte_pkg::MAX_VERTICES_DEF;
  localparam int NE = gte_pkg::MAX_EDGES_DEF;
  localparam logic [8:0] NIL = 9'(NE);

  typedef struct packed {
    logic [gte_pkg::VERTEX_W-1:0] vtx;
    logic [gte_pkg::STATUS_W-1:0] st;
    logic                         lst;
  } outcome_t;

  outcome_t due_q[$];

  logic [8:0]                   head[NV];
  logic [8:0]                   tail_e[NV];
  logic [8:0]                   cursor[NV];
  logic [8:0]                   link[NE];
  logic [gte_pkg::VERTEX_W-1:0] target[NE];
  logic [gte_pkg::VERTEX_W-1:0] pend[NV];
  logic                         seen[NV];
  int                           edges;
  int                           vcount;
  logic                         dfs;

  task automatic queue_outcome(input outcome_t o);
    due_q = {due_q, o};
  endtask

  task automatic push_status(input logic [gte_pkg::STATUS_W-1:0] st);
    outcome_t o;
    o.vtx = '0;
    o.st  = st;
    o.lst = 1'b1;
    queue_outcome(o);
  endtask

  task automatic mark_visit(input logic [gte_pkg::VERTEX_W-1:0] v);
    outcome_t o;
    seen[v] = 1'b1;
    o.vtx = v;
    o.st  = gte_pkg::ST_VISITED;
    o.lst = 1'b0;
    queue_outcome(o);
  endtask

  task automatic add_edge(input logic [gte_pkg::VERTEX_W-1:0] v,
                          input logic [gte_pkg::VERTEX_W-1:0] w);
    if (v >= vcount || w >= vcount) begin
      push_status(gte_pkg::ST_OUT_RANGE);
    end else if (edges >= NE) begin
      push_status(gte_pkg::ST_FULL);
    end else begin
      target[edges] = w;
      link[edges]   = NIL;
      if (head[v] == NIL) head[v] = 9'(edges);
      else link[tail_e[v][7:0]] = 9'(edges);
      tail_e[v] = 9'(edges);
      edges++;
    end
  endtask

  task automatic walk_breadth(input logic [gte_pkg::VERTEX_W-1:0] s);
    int front, back;
    logic [8:0] e;
    logic [gte_pkg::VERTEX_W-1:0] t, w;
    front = 0;
    back  = 0;
    mark_visit(s);
    pend[back++] = s;
    while (front < back) begin
      t = pend[front++];
      e = head[t];
      while (e != NIL) begin
        w = target[e[7:0]];
        if (w < vcount && !seen[w] && back < NV) begin
          mark_visit(w);
          pend[back++] = w;
        end
        e = link[e[7:0]];
      end
    end
  endtask

  // preorder with a per-vertex edge cursor, same order as the recursive walk
  task automatic walk_depth(input logic [gte_pkg::VERTEX_W-1:0] s);
    int top;
    logic pushed;
    logic [8:0] e;
    logic [gte_pkg::VERTEX_W-1:0] t, w;
    top = 0;
    mark_visit(s);
    cursor[s] = head[s];
    pend[top++] = s;
    while (top > 0) begin
      t = pend[top-1];
      e = cursor[t];
      pushed = 1'b0;
      while (e != NIL && !pushed) begin
        w = target[e[7:0]];
        e = link[e[7:0]];
        if (w < vcount && !seen[w] && top < NV) begin
          cursor[t] = e;
          mark_visit(w);
          cursor[w] = head[w];
          pend[top++] = w;
          pushed = 1'b1;
        end
      end
      if (!pushed) begin
        cursor[t] = NIL;
        top--;
      end
    end
  endtask

  task automatic apply_item(input logic [gte_pkg::OPCODE_W-1:0] op,
                            input logic [gte_pkg::VERTEX_W-1:0] v,
                            input logic [gte_pkg::VERTEX_W-1:0] w);
    case (op)
      gte_pkg::OP_ADD_EDGE: add_edge(v, w);
      gte_pkg::OP_TRAVERSE: begin
        if (v >= vcount) begin
          push_status(gte_pkg::ST_OUT_RANGE);
        end else begin
          foreach (seen[i]) seen[i] = 1'b0;
          if (dfs) walk_depth(v);
          else walk_breadth(v);
          due_q[due_q.size()-1].lst = 1'b1;
        end
      end
      gte_pkg::OP_CLEAR: begin
        foreach (head[i]) head[i] = NIL;
        edges = 0;
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    outcome_t exp;
    if (due_q.size() == 0) begin
      $error("result with nothing expected: vertex %0d status %0d last %0d",
             results.visited_vertex, results.status, results.last);
      error_count++;
    end else begin
      exp = due_q.pop_front();
      if (results.visited_vertex !== exp.vtx) begin
        $error("visited_vertex expected %0d actual %0d", exp.vtx, results.visited_vertex);
        error_count++;
      end
      if (results.status !== exp.st) begin
        $error("status expected %0d actual %0d", exp.st, results.status);
        error_count++;
      end
      if (results.last !== exp.lst) begin
        $error("last expected %0d actual %0d", exp.lst, results.last);
        error_count++;
      end
    end
    result_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (head[i]) head[i] = NIL;
      edges        = 0;
      vcount       = NV;
      dfs          = 1'b0;
      due_q.delete();
      error_count  = 0;
      result_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == gte_pkg::REG_VERTEX_COUNT) begin
          vcount = int'(cfg.data);
          if (vcount < 1) vcount = 1;
          if (vcount > NV) vcount = NV;
        end else if (cfg.index == gte_pkg::REG_TRAVERSAL_ORDER) begin
          dfs = cfg.data[0];
        end
      end
      if (results.valid && results.ready) check_result();
      if (items.valid && items.ready)
        apply_item(items.opcode, items.vertex, items.neighbor_vertex);
    end
    awaited = due_q.size();
  end

endmodule

// ----- verif/graph_traversal_engine_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_traversal_engine_top_tb
// Drives edge, traverse and clear items under random idling and config
// changes; the scoreboard predicts and checks every result transfer.
// ----------------------------------------------------------------------------
module graph_traversal_engine_top_tb;

  localparam int IDLE_LIMIT = 20000;
  // opcode with no function, must be ignored
  localparam logic [gte_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gte_item_if   items ();
  gte_result_if results ();
  gte_cfg_if    cfg ();

  int error_count, awaited, result_count;
  int sent, n_trav, n_add, idle_cycles;
  int vc;
  logic steady_send, steady_recv, long_hold;

  always #5 clk = ~clk;

  graph_traversal_engine_top dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg)
  );

  gte_scoreboard chk (
    .clk          (clk),
    .rst          (rst),
    .items        (items),
    .results      (results),
    .cfg          (cfg),
    .error_count  (error_count),
    .awaited      (awaited),
    .result_count (result_count)
  );

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result receiver
  initial begin
    int n;
    results.ready <= 1'b0;
    wait (!rst);
    forever begin
      n = steady_recv ? 0 : $urandom_range(0, 9);
      if (long_hold) begin
        results.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        n = 0;
      end
      if (n > 0) begin
        results.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      results.ready <= 1'b1;
      @(posedge clk);
      while (!results.valid) @(posedge clk);
    end
  end

  task automatic send_item(input logic [gte_pkg::OPCODE_W-1:0] op,
                           input logic [gte_pkg::VERTEX_W-1:0] v,
                           input logic [gte_pkg::VERTEX_W-1:0] w);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      items.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items.opcode          <= op;
    items.vertex          <= v;
    items.neighbor_vertex <= w;
    items.valid           <= 1'b1;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    sent++;
    if (op == gte_pkg::OP_TRAVERSE) n_trav++;
    if (op == gte_pkg::OP_ADD_EDGE) n_add++;
  endtask

  // wait until every predicted result has arrived and the engine is quiet
  task automatic drain();
    items.valid <= 1'b0;
    @(posedge clk);
    wait (awaited == 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [gte_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gte_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg.index <= idx;
    cfg.data  <= d;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == gte_pkg::REG_VERTEX_COUNT) vc = (d < 1) ? 1 : (d > 64) ? 64 : int'(d);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62)
      send_item(gte_pkg::OP_ADD_EDGE, 6'($urandom_range(0, vc - 1)),
                6'($urandom_range(0, vc - 1)));
    else if (r < 67)
      send_item(gte_pkg::OP_ADD_EDGE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    else if (r < 90)
      send_item(gte_pkg::OP_TRAVERSE, 6'($urandom_range(0, vc - 1)),
                6'($urandom_range(0, 63)));
    else if (r < 95)
      send_item(gte_pkg::OP_TRAVERSE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    else if (r < 97)
      send_item(gte_pkg::OP_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
    else
      send_item(OP_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
  endtask

  initial begin
    items.valid <= 1'b0;
    items.opcode <= gte_pkg::OP_ADD_EDGE;
    items.vertex <= '0;
    items.neighbor_vertex <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= gte_pkg::REG_VERTEX_COUNT;
    cfg.data <= '0;
    steady_send = 1'b0;
    steady_recv = 1'b0;
    long_hold = 1'b0;
    sent = 0;
    n_trav = 0;
    n_add = 0;
    vc = 64;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty graph, default config
    send_item(gte_pkg::OP_TRAVERSE, 6'd0, 6'd63);
    send_item(gte_pkg::OP_TRAVERSE, 6'd63, 6'd0);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd0, 6'd1);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd0, 6'd2);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd1, 6'd3);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd2, 6'd3);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd3, 6'd0);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd1, 6'd1);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd63, 6'd62);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd62, 6'd63);
    send_item(OP_UNUSED, 6'd63, 6'd63);
    send_item(gte_pkg::OP_TRAVERSE, 6'd0, 6'd0);
    send_item(gte_pkg::OP_TRAVERSE, 6'd62, 6'd0);
    drain();
    cfg_write(gte_pkg::REG_TRAVERSAL_ORDER, 7'd1);
    send_item(gte_pkg::OP_TRAVERSE, 6'd0, 6'd0);
    drain();
    // shrink the vertex range: edges into vertex 3 go stale
    cfg_write(gte_pkg::REG_VERTEX_COUNT, 7'd3);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd5, 6'd0);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd0, 6'd5);
    send_item(gte_pkg::OP_TRAVERSE, 6'd4, 6'd0);
    send_item(gte_pkg::OP_TRAVERSE, 6'd0, 6'd0);
    send_item(gte_pkg::OP_CLEAR, 6'd0, 6'd0);
    send_item(gte_pkg::OP_TRAVERSE, 6'd0, 6'd0);
    drain();
    cfg_write(gte_pkg::REG_VERTEX_COUNT, 7'd0);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd0, 6'd0);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd0, 6'd1);
    send_item(gte_pkg::OP_TRAVERSE, 6'd0, 6'd0);
    drain();
    cfg_write(gte_pkg::REG_VERTEX_COUNT, 7'd127);

    // random phases
    for (int ph = 0; ph < 9; ph++) begin
      drain();
      cfg_write(gte_pkg::REG_VERTEX_COUNT,
                (ph % 3 == 2) ? 7'd64 : 7'($urandom_range(2, 16)));
      cfg_write(gte_pkg::REG_TRAVERSAL_ORDER, 7'($urandom_range(0, 127)));
      steady_send = ($urandom_range(0, 3) == 0);
      steady_recv = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) send_item(gte_pkg::OP_CLEAR, 6'd0, 6'd0);
      for (int k = 0; k < 20; k++) begin
        if (ph == 4 && k == 10) long_hold = 1'b1;
        if (k == 16 && ph % 2 == 1) drain();
        random_item();
      end
    end

    // one walk in each order over the graph that is left
    drain();
    steady_send = 1'b0;
    steady_recv = 1'b0;
    cfg_write(gte_pkg::REG_VERTEX_COUNT, 7'd64);
    cfg_write(gte_pkg::REG_TRAVERSAL_ORDER, 7'd0);
    send_item(gte_pkg::OP_TRAVERSE, 6'($urandom_range(0, 63)), 6'd0);
    drain();
    cfg_write(gte_pkg::REG_TRAVERSAL_ORDER, {6'd0, 1'b1});
    send_item(gte_pkg::OP_TRAVERSE, 6'($urandom_range(0, 63)), 6'd0);
    send_item(gte_pkg::OP_ADD_EDGE, 6'd63, 6'd63);

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d items (%0d edge adds, %0d traversals), %0d results checked,",
             sent, n_add, n_trav, result_count);
    $display("both walk orders, vertex counts 1 to 64, stale edges and a long result stall.");
    if (error_count == 0 && awaited == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- graph_traversal_engine_top.f -----
design/gte_pkg.sv
design/gte_item_if.sv
design/gte_result_if.sv
design/gte_cfg_if.sv
design/gte_ctrl.sv
design/gte_dp.sv
design/graph_traversal_engine_top.sv
verif/gte_scoreboard.sv
verif/graph_traversal_engine_top_tb.sv
